>>> hw/rtl/sbon_pkg.sv
package sbon_pkg;

  localparam int unsigned MaskW = 8;
  localparam int unsigned TickW = 16;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned SlotW = 4;

  // Hard ceiling on the number of client slots; the masks are this wide.
  localparam int unsigned MaxClients = 8;

  typedef enum logic [2:0] {
    CmdRegister   = 3'd0,
    CmdUnregister = 3'd1,
    CmdRequest    = 3'd2,
    CmdRelease    = 3'd3,
    CmdTick       = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StInvalid = 3'd1,
    StWaiting = 3'd2,
    StTimeout = 3'd3,
    StBusy    = 3'd4,
    StNothing = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CfgMode       = 2'd0,
    CfgMaxClients = 2'd1,
    CfgReqTimeout = 2'd2,
    CfgRelTimeout = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [MaskW-1:0] mask;
    logic             partner;
  } item_t;

  typedef struct packed {
    status_e          status;
    logic [MaskW-1:0] assigned;
    logic             owner;
    logic [MaskW-1:0] requested;
  } result_t;

  typedef struct packed {
    logic            we;
    cfg_idx_e        idx;
    logic [CfgW-1:0] wdata;
  } cfg_wr_t;

endpackage

>>> hw/rtl/sbon_core.sv
module sbon_core import sbon_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    en_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic             mode_q;
  logic [SlotW-1:0] max_clients_q;
  logic [TickW-1:0] req_to_q, rel_to_q;

  logic [MaskW-1:0] reg_q, reg_d, req_q, req_d;
  logic             waiting_q, waiting_d;
  logic             target_q, target_d;
  logic             owner_q, owner_d;
  logic [TickW-1:0] ticks_q, ticks_d;

  logic [MaskW-1:0] limit_mask, free_mask, lowest_free;
  logic [TickW-1:0] req_load, rel_load, ticks_dec;
  status_e          status;
  logic [MaskW-1:0] assigned;
  cmd_e             cmd;

  assign cmd = cmd_e'(item_i.cmd);

  always_comb begin
    for (int i = 0; i < MaskW; i++) begin
      limit_mask[i] = ({{(32-SlotW){1'b0}}, max_clients_q} > i) && (i < MaxClients);
    end
  end

  assign free_mask   = ~reg_q & limit_mask;
  assign lowest_free = free_mask & (~free_mask + {{(MaskW-1){1'b0}}, 1'b1});

  // A zero timeout behaves as a single tick.
  assign req_load  = (req_to_q == '0) ? {{(TickW-1){1'b0}}, 1'b1} : req_to_q;
  assign rel_load  = (rel_to_q == '0) ? {{(TickW-1){1'b0}}, 1'b1} : rel_to_q;
  assign ticks_dec = (ticks_q != '0) ? ticks_q - {{(TickW-1){1'b0}}, 1'b1} : ticks_q;

  always_comb begin
    reg_d     = reg_q;
    req_d     = req_q;
    waiting_d = waiting_q;
    target_d  = target_q;
    owner_d   = owner_q;
    ticks_d   = ticks_q;
    status    = StNothing;
    assigned  = '0;
    priority if (waiting_q && (cmd == CmdRegister || cmd == CmdUnregister ||
                               cmd == CmdRequest || cmd == CmdRelease)) begin
      status = StBusy;
    end else begin
      unique case (cmd)
        CmdRegister: begin
          assigned = lowest_free;
          reg_d    = reg_q | lowest_free;
          req_d    = req_q | lowest_free;
          status   = StOk;
        end
        CmdUnregister: begin
          reg_d  = reg_q & ~item_i.mask;
          status = StOk;
        end
        CmdRequest: begin
          if ((item_i.mask & reg_q) == '0) begin
            status = StInvalid;
          end else begin
            status = StOk;
            if (req_q == '0 && !mode_q) begin
              owner_d   = 1'b0;
              target_d  = 1'b0;
              ticks_d   = req_load;
              waiting_d = 1'b1;
              status    = StWaiting;
            end
            req_d = req_q | item_i.mask;
          end
        end
        CmdRelease: begin
          if ((item_i.mask & reg_q) == '0) begin
            status = StInvalid;
          end else if (req_q == '0) begin
            status = StOk;
          end else begin
            status = StOk;
            if (req_q == item_i.mask && !mode_q) begin
              owner_d   = 1'b1;
              target_d  = 1'b1;
              ticks_d   = rel_load;
              waiting_d = 1'b1;
              status    = StWaiting;
            end
            req_d = req_q & ~item_i.mask;
          end
        end
        CmdTick: begin
          if (waiting_q) begin
            if (item_i.partner == target_q) begin
              waiting_d = 1'b0;
              ticks_d   = '0;
              status    = StOk;
            end else begin
              ticks_d = ticks_dec;
              if (ticks_dec == '0) begin
                waiting_d = 1'b0;
                status    = StTimeout;
              end else begin
                status = StWaiting;
              end
            end
          end
        end
        default: status = StNothing;
      endcase
    end
  end

  assign result_o.status    = status;
  assign result_o.assigned  = assigned;
  assign result_o.owner     = owner_d;
  assign result_o.requested = req_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= 1'b0;
      max_clients_q <= SlotW'(1);
      req_to_q      <= TickW'(500);
      rel_to_q      <= TickW'(500);
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CfgMode:       mode_q        <= cfg_i.wdata[0];
        CfgMaxClients: max_clients_q <= cfg_i.wdata[SlotW-1:0];
        CfgReqTimeout: req_to_q      <= cfg_i.wdata[TickW-1:0];
        CfgRelTimeout: rel_to_q      <= cfg_i.wdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q     <= '0;
      req_q     <= '0;
      waiting_q <= 1'b0;
      target_q  <= 1'b0;
      owner_q   <= 1'b0;
      ticks_q   <= '0;
    end else if (en_i) begin
      reg_q     <= reg_d;
      req_q     <= req_d;
      waiting_q <= waiting_d;
      target_q  <= target_d;
      owner_q   <= owner_d;
      ticks_q   <= ticks_d;
    end
  end

  // The tick counter is non-zero exactly while a handshake is running.
  a_wait_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    waiting_q == (ticks_q != '0))
    else $error("wait flag and tick count disagree");

  // A rejected command leaves both client masks untouched.
  a_busy_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && status == StBusy) |=> ($stable(reg_q) && $stable(req_q)))
    else $error("busy command changed the client masks");

  // Registration hands out at most one slot, and only a free one.
  a_assign_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |-> ($onehot0(assigned) && ((assigned & reg_q) == '0)))
    else $error("register gave a taken or multiple slot");

endmodule

>>> hw/rtl/shared_bus_ownership_negotiator_top.sv
// Channel   | Direction | tdata (low bit up)                         | tuser
// s_axis    | in        | client_mask[7:0], partner_line             | command[2:0]
// m_axis    | out       | assigned_mask[7:0], owner_drive, requested_now[7:0] | status[2:0]
// cfg       | in        | cfg_idx_i selects register, cfg_wdata_i is the value | -
//
// Each transaction passes through the input register and then the result
// register; the command logic between them is combinational, so one
// transaction is accepted per clock unless the result channel stalls.
// Reset is asynchronous and active low; it clears the client masks, the wait
// state and the owner line, and loads the register defaults.
// A stalled result stalls the input register only once both are full.
module shared_bus_ownership_negotiator_top import sbon_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // client_mask[7:0], partner_line[8], zero fill to bit 15.
  input  logic [15:0] s_axis_tdata,
  // command[2:0].
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // assigned_mask[7:0], owner_drive[8], requested_now[16:9], zero fill to bit 23.
  output logic [23:0] m_axis_tdata,
  // status[2:0].
  output logic [2:0]  m_axis_tuser
);

  item_t   item_q;
  logic    in_valid_q;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    advance;
  cfg_wr_t cfg;

  // An item moves into the result register when that register is empty or
  // its transaction completes in this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = cfg_idx_e'(cfg_idx_i);
  assign cfg.wdata = cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.cmd     <= s_axis_tuser;
      item_q.mask    <= s_axis_tdata[7:0];
      item_q.partner <= s_axis_tdata[8];
    end
  end

  sbon_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .en_i     (advance),
    .item_i   (item_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {7'b0, res_q.requested, res_q.owner, res_q.assigned};

endmodule

>>> tb/sv/tb_shared_bus_ownership_negotiator_top.sv
`timescale 1ns / 100ps

module tb_shared_bus_ownership_negotiator_top import sbon_pkg::*;;

  // Commands 5 to 7 are not defined; the block must ignore them.
  localparam logic [2:0] FirstSpareCmd = 3'd5;
  localparam logic [2:0] LastSpareCmd  = 3'd7;

  // Input transactions per random phase.
  localparam int unsigned PhaseCount    = 12;
  localparam int unsigned ItemsPerPhase = 150;
  // The result side refuses every transaction for this many cycles during the long hold-off.
  localparam int unsigned LongHoldCycles = 64;
  // Settling time after the last expected result, before the next step.
  localparam int unsigned SettleCycles = 4;

  typedef enum int unsigned {
    SinkAlways,
    SinkLight,
    SinkPattern,
    SinkHeavy
  } sink_style_e;

  // Shadow of the negotiator: its registers and state advance once per accepted
  // transaction, and every transaction leaves one expected result in the queue.
  class ownership_tracker;
    logic              mode;
    logic [3:0]        max_clients;
    logic [TickW-1:0]  req_timeout;
    logic [TickW-1:0]  rel_timeout;
    logic [MaskW-1:0]  registered;
    logic [MaskW-1:0]  requesting;
    logic              waiting;
    logic              wait_target;
    logic [TickW-1:0]  ticks_left;
    logic              owner_line;
    result_t           expected_outcomes[$];
    int unsigned       mismatch_count;

    function new();
      mode           = 1'b0;
      max_clients    = 4'd1;
      req_timeout    = 16'd500;
      rel_timeout    = 16'd500;
      registered     = '0;
      requesting     = '0;
      waiting        = 1'b0;
      wait_target    = 1'b0;
      ticks_left     = '0;
      owner_line     = 1'b0;
      mismatch_count = 0;
    endfunction

    function void write_register(cfg_idx_e idx, logic [CfgW-1:0] value);
      case (idx)
        CfgMode:       mode        = value[0];
        CfgMaxClients: max_clients = value[3:0];
        CfgReqTimeout: req_timeout = value;
        CfgRelTimeout: rel_timeout = value;
        default: ;
      endcase
    endfunction

    // Drives the owner line and arms the tick countdown, unless in mock mode.
    function status_e begin_wait(logic target, logic [TickW-1:0] timeout);
      if (mode) return StOk;
      owner_line  = target;
      wait_target = target;
      ticks_left  = (timeout == '0) ? 16'd1 : timeout;
      waiting     = 1'b1;
      return StWaiting;
    endfunction

    function status_e note_command(logic [2:0] cmd, logic [MaskW-1:0] mask, logic partner);
      result_t     r;
      int unsigned limit;
      bit          found;
      int          i;
      r.status   = StNothing;
      r.assigned = '0;
      if (cmd <= CmdRelease && waiting) begin
        r.status = StBusy;
      end else begin
        case (cmd)
          CmdRegister: begin
            limit = (max_clients > MaxClients) ? MaxClients : max_clients;
            if (limit > MaskW) limit = MaskW;
            found = 1'b0;
            for (i = 0; i < MaskW; i++) begin
              if (!found && i < limit && !registered[i]) begin
                found         = 1'b1;
                registered[i] = 1'b1;
                requesting[i] = 1'b1;
                r.assigned[i] = 1'b1;
              end
            end
            r.status = StOk;
          end
          CmdUnregister: begin
            registered = registered & ~mask;
            r.status   = StOk;
          end
          CmdRequest: begin
            if ((mask & registered) == '0) begin
              r.status = StInvalid;
            end else begin
              r.status = StOk;
              if (requesting == '0) r.status = begin_wait(1'b0, req_timeout);
              requesting = requesting | mask;
            end
          end
          CmdRelease: begin
            if ((mask & registered) == '0) begin
              r.status = StInvalid;
            end else if (requesting == '0) begin
              r.status = StOk;
            end else begin
              r.status = StOk;
              if (requesting == mask) r.status = begin_wait(1'b1, rel_timeout);
              requesting = requesting & ~mask;
            end
          end
          CmdTick: begin
            if (waiting) begin
              if (partner == wait_target) begin
                waiting    = 1'b0;
                ticks_left = '0;
                r.status   = StOk;
              end else begin
                if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
                if (ticks_left == '0) begin
                  waiting  = 1'b0;
                  r.status = StTimeout;
                end else begin
                  r.status = StWaiting;
                end
              end
            end
          end
          default: ;
        endcase
      end
      r.owner     = owner_line;
      r.requested = requesting;
      expected_outcomes.push_back(r);
      return r.status;
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 100) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_outcome(logic [2:0] status, logic [MaskW-1:0] assigned, logic owner,
                       logic [MaskW-1:0] requested);
      result_t want;
      if (expected_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding, status %0d", status));
        return;
      end
      want = expected_outcomes.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
      if (assigned !== want.assigned)
        report_mismatch($sformatf("assigned_mask %h, wanted %h", assigned, want.assigned));
      if (owner !== want.owner)
        report_mismatch($sformatf("owner_drive %b, wanted %b", owner, want.owner));
      if (requested !== want.requested)
        report_mismatch($sformatf("requested_now %h, wanted %h", requested, want.requested));
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  ownership_tracker tracker;
  int unsigned      counted_items;
  // Raised by the stimulus process; the result sink clears it when the hold-off begins.
  bit               long_hold_pending = 1'b0;

  shared_bus_ownership_negotiator_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 8 ns clock period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Every result transaction is compared with the oldest outstanding expectation.
  // Values are sampled at the edge, before any register in the block updates.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_outcome(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8],
                            m_axis_tdata[16:9]);
    end
  end

  // Holds one command on the input channel until the block accepts it. The valid
  // line is left high so that a following command can go straight out.
  task automatic offer_command(input logic [2:0] cmd, input logic [MaskW-1:0] mask,
                               input logic partner);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'b0, partner, mask};
    do @(posedge clk_i); while (!s_axis_tready);
    void'(tracker.note_command(cmd, mask, partner));
    counted_items++;
  endtask

  task automatic idle_input(input int unsigned cycles);
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stops sending and lets every outstanding result drain out of the block.
  task automatic wait_for_results();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (tracker.expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register writes are only made once the block has gone quiet.
  task automatic set_register(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    tracker.write_register(idx, value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly a subset of the given pool of clients, so that requests and releases
  // find registered slots; an empty draw falls back to the whole pool.
  function automatic logic [MaskW-1:0] draw_from(input logic [MaskW-1:0] pool);
    logic [MaskW-1:0] m;
    m = pool & MaskW'($urandom_range(0, 255));
    return (m == '0) ? pool : m;
  endfunction

  // The first few phases pin the corners of the register space; the rest are random.
  task automatic configure_phase(input int unsigned phase);
    logic             mode_v;
    logic [3:0]       clients_v;
    logic [TickW-1:0] req_v;
    logic [TickW-1:0] rel_v;
    mode_v    = 1'($urandom_range(0, 1));
    clients_v = 4'($urandom_range(0, 15));
    req_v     = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 10));
    rel_v     = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 10));
    case (phase)
      0: begin mode_v = 1'b0; clients_v = 4'd8;  req_v = 16'd3;     rel_v = 16'd5;     end
      1: begin mode_v = 1'b1; clients_v = 4'd8;  req_v = 16'd2;     rel_v = 16'd2;     end
      2: begin mode_v = 1'b0; clients_v = 4'd1;  req_v = 16'd1;     rel_v = 16'd1;     end
      3: begin mode_v = 1'b0; clients_v = 4'd0;  req_v = 16'd0;     rel_v = 16'd0;     end
      4: begin mode_v = 1'b0; clients_v = 4'd15; req_v = 16'hFFFF; rel_v = 16'hFFFF; end
      default: ;
    endcase
    set_register(CfgMode, {15'b0, mode_v});
    set_register(CfgMaxClients, {12'b0, clients_v});
    set_register(CfgReqTimeout, req_v);
    set_register(CfgRelTimeout, rel_v);
  endtask

  // Picks a command shaped by the shadow state: during a handshake mostly ticks,
  // with the partner line matching about a third of the time; otherwise registrations,
  // unregistrations, bus requests and releases on registered clients, ticks, spare commands.
  task automatic offer_random_command();
    logic [2:0]       cmd;
    logic [MaskW-1:0] mask;
    logic             partner;
    int unsigned      pick;
    pick    = $urandom_range(0, 99);
    partner = 1'($urandom_range(0, 1));
    mask    = MaskW'($urandom_range(0, 255));
    if (tracker.waiting) begin
      if (pick < 75) begin
        cmd     = CmdTick;
        partner = (pick < 25) ? tracker.wait_target : !tracker.wait_target;
      end else if (pick < 95) begin
        cmd = 3'($urandom_range(CmdRegister, CmdRelease));
      end else begin
        cmd = 3'($urandom_range(FirstSpareCmd, LastSpareCmd));
      end
    end else if (pick < 20) begin
      cmd = CmdRegister;
    end else if (pick < 30) begin
      cmd = CmdUnregister;
      if (pick < 26 && tracker.registered != '0) mask = draw_from(tracker.registered);
    end else if (pick < 55) begin
      cmd = CmdRequest;
      if (pick < 50 && tracker.registered != '0) mask = draw_from(tracker.registered);
    end else if (pick < 80) begin
      cmd = CmdRelease;
      if (pick < 68 && tracker.requesting != '0) mask = tracker.requesting;
      else if (pick < 76 && tracker.requesting != '0) mask = draw_from(tracker.requesting);
    end else if (pick < 95) begin
      cmd = CmdTick;
    end else begin
      cmd = 3'($urandom_range(FirstSpareCmd, LastSpareCmd));
    end
    offer_command(cmd, mask, partner);
  endtask

  // Result sink: the ready line follows a style that changes now and then, and
  // once on request it refuses everything for a long stretch so that both
  // pipeline registers fill and the input channel is held off.
  initial begin : result_sink
    sink_style_e style;
    int unsigned style_left;
    int unsigned cycle_count;
    style       = SinkAlways;
    style_left  = 200;
    cycle_count = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
      end else begin
        case (style)
          SinkAlways:  m_axis_tready <= 1'b1;
          SinkLight:   m_axis_tready <= ($urandom_range(0, 3) != 0);
          SinkPattern: m_axis_tready <= ((cycle_count % 7) < 3);
          default:     m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk_i);
        cycle_count++;
        if (style_left == 0) begin
          style      = sink_style_e'($urandom_range(SinkAlways, SinkHeavy));
          style_left = $urandom_range(20, 300);
        end else begin
          style_left--;
        end
      end
    end
  end

  // Stimulus: a directed opening on the reset register values, a short second
  // directed run with a zero request timeout, then random phases.
  initial begin : stimulus
    int unsigned burst_left;
    int unsigned phase_target;
    tracker       = new();
    counted_items = 0;
    burst_left    = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: line mode, one client slot, 500-tick timeouts.
    offer_command(CmdTick, 8'h00, 1'b0);        // tick with no handshake running
    offer_command(LastSpareCmd, 8'hFF, 1'b1);   // undefined command
    offer_command(CmdRequest, 8'hFF, 1'b0);     // nobody registered: invalid mask
    offer_command(CmdRegister, 8'h00, 1'b0);    // takes slot 0
    offer_command(CmdRegister, 8'h00, 1'b1);    // slot limit reached
    offer_command(CmdRelease, 8'h01, 1'b0);     // last requester leaves: handshake
    offer_command(CmdRequest, 8'h01, 1'b0);     // busy during the handshake
    offer_command(CmdTick, 8'h00, 1'b0);        // partner has not taken the bus yet
    offer_command(FirstSpareCmd, 8'h00, 1'b0);  // undefined command while waiting
    offer_command(CmdTick, 8'h00, 1'b1);        // partner takes the bus
    offer_command(CmdRelease, 8'h01, 1'b1);     // bus already released
    offer_command(CmdRequest, 8'hFF, 1'b1);     // request from an idle bus
    offer_command(CmdTick, 8'h00, 1'b0);        // partner yields
    offer_command(CmdRequest, 8'h01, 1'b0);     // bus already held
    offer_command(CmdRelease, 8'h81, 1'b0);     // partial release
    offer_command(CmdUnregister, 8'hFF, 1'b0);  // requesting bits stay
    offer_command(CmdRelease, 8'h02, 1'b0);     // invalid mask after unregister
    wait_for_results();

    set_register(CfgMaxClients, 16'd8);
    set_register(CfgReqTimeout, 16'd0);
    set_register(CfgRelTimeout, 16'd2);
    offer_command(CmdRegister, 8'h00, 1'b0);
    offer_command(CmdRegister, 8'h00, 1'b0);
    offer_command(CmdRelease, 8'h7F, 1'b0);     // handshake with a two-tick limit
    offer_command(CmdTick, 8'h00, 1'b0);
    offer_command(CmdTick, 8'h00, 1'b0);        // times out
    offer_command(CmdRequest, 8'h02, 1'b1);     // zero timeout behaves as one tick
    offer_command(CmdTick, 8'h00, 1'b1);        // times out at once
    wait_for_results();

    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      configure_phase(phase);
      phase_target = counted_items + ItemsPerPhase;
      while (counted_items < phase_target) begin
        if (phase == 0 && counted_items + ItemsPerPhase - phase_target == 40)
          long_hold_pending = 1'b1;
        if (phase == 2 && counted_items + ItemsPerPhase - phase_target == 75) begin
          wait_for_results();
          burst_left = 0;
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 6));
        end
        burst_left--;
        offer_random_command();
      end
      wait_for_results();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.expected_outcomes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
